// ===== src/ttpc_pkg.sv =====
// package: widths, codes, configuration type and slope constant tables
package ttpc_pkg;

	// item and register widths
	localparam int RAM_W      = 10;
	localparam int TEMP_W     = 12;
	localparam int BAT_W      = 7;
	localparam int THR_W      = 10;
	localparam int CHG_W      = 11;
	localparam int CODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// window geometry
	localparam int WINDOW_DEPTH = 10;
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int RAM_MAX = (1 << RAM_W) - 1;
	localparam int SY_W    = $clog2(WINDOW_DEPTH * RAM_MAX + 1);
	localparam int SX_MAX  = WINDOW_DEPTH * (WINDOW_DEPTH - 1) / 2;
	localparam int SX_W    = $clog2(SX_MAX + 1);
	localparam int SXY_W   = $clog2(RAM_MAX * SX_MAX + 1);
	localparam int DEN_W   =
		$clog2(WINDOW_DEPTH * WINDOW_DEPTH * (WINDOW_DEPTH * WINDOW_DEPTH - 1) / 12 + 1);
	localparam int TAB_N   = 1 << CNT_W;

	// product widths and the signed compare width
	localparam int PA_W   = CNT_W + SXY_W;
	localparam int PB_W   = SX_W + SY_W;
	localparam int LIM_W  = THR_W + DEN_W;
	localparam int MAX_AB = (PA_W > PB_W) ? PA_W : PB_W;
	localparam int CMP_W  = ((MAX_AB > LIM_W) ? MAX_AB : LIM_W) + 2;

	// minimum samples for a slope
	localparam int MIN_FIT = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAM_WARN  = 3'd0,
		CFG_RAM_CRIT  = 3'd1,
		CFG_TH_WARN   = 3'd2,
		CFG_TH_CRIT   = 3'd3,
		CFG_BAT_LOW   = 3'd4,
		CFG_TREND_THR = 3'd5
	} cfg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		PRESSURE_NOMINAL  = 2'd0,
		PRESSURE_WARN     = 2'd1,
		PRESSURE_CRITICAL = 2'd2
	} pressure_t;

	typedef enum logic [CODE_W-1:0] {
		TREND_STABLE  = 2'd0,
		TREND_RISING  = 2'd1,
		TREND_FALLING = 2'd2
	} trend_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MULT,
		ST_DECIDE
	} eng_state_t;

	typedef struct packed {
		logic [RAM_W-1:0]         mem_warn;
		logic [RAM_W-1:0]         mem_crit;
		logic signed [TEMP_W-1:0] th_warn;
		logic signed [TEMP_W-1:0] th_crit;
		logic [BAT_W-1:0]         bat_low;
		logic [THR_W-1:0]         trend_thr;
	} ttpc_cfg_t;

	// result handed from the trend engine to the output register
	typedef struct packed {
		logic                    done;
		trend_t                  trend_code;
		logic signed [CHG_W-1:0] ram_change;
	} ttpc_eng_res_t;

	typedef logic [SX_W-1:0]  sx_table_t  [TAB_N];
	typedef logic [DEN_W-1:0] den_table_t [TAB_N];

	// sum of x over 0..n-1
	function automatic sx_table_t build_sx_table();
		sx_table_t t;
		for (int k = 0; k < TAB_N; k++) begin
			t[k] = (k <= WINDOW_DEPTH) ? SX_W'(k * (k - 1) / 2) : '0;
		end
		return t;
	endfunction

	// n*Sxx - Sx*Sx = n^2 (n^2 - 1) / 12
	function automatic den_table_t build_den_table();
		den_table_t t;
		for (int k = 0; k < TAB_N; k++) begin
			t[k] = (k <= WINDOW_DEPTH) ? DEN_W'(k * k * (k * k - 1) / 12) : '0;
		end
		return t;
	endfunction

	localparam sx_table_t  SX_TABLE  = build_sx_table();
	localparam den_table_t DEN_TABLE = build_den_table();

	localparam ttpc_cfg_t CFG_RESET = '{
		mem_warn:  RAM_W'(750),
		mem_crit:  RAM_W'(900),
		th_warn:   TEMP_W'(700),
		th_crit:   TEMP_W'(850),
		bat_low:   BAT_W'(15),
		trend_thr: THR_W'(5)
	};

endpackage

// ===== src/ttpc_in_if.sv =====
// interface: telemetry sample channel
interface ttpc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [ttpc_pkg::RAM_W-1:0]            mem_use;
	logic signed [ttpc_pkg::TEMP_W-1:0]    temperature;
	logic [ttpc_pkg::BAT_W-1:0]            battery_level;
	logic                                  battery_present;
	logic                                  charging;

	modport source (output valid, mem_use, temperature, battery_level,
		battery_present, charging, input ready);
	modport sink (input valid, mem_use, temperature, battery_level,
		battery_present, charging, output ready);
endinterface

// ===== src/ttpc_out_if.sv =====
// interface: classification result channel
interface ttpc_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [ttpc_pkg::CODE_W-1:0]          pressure_level;
	logic [ttpc_pkg::CODE_W-1:0]          trend_code;
	logic signed [ttpc_pkg::CHG_W-1:0]    ram_change;

	modport source (output valid, pressure_level, trend_code, ram_change, input ready);
	modport sink (input valid, pressure_level, trend_code, ram_change, output ready);
endinterface

// ===== src/telemetry_trend_pressure_classifier_unit.sv =====
// top level: configuration registers, sample intake and result register
// each telemetry sample beat yields exactly one result beat holding the
// pressure level (critical, warn or nominal from memory use, temperature and
// the low battery rule), the memory trend (least-squares slope over the last
// ten memory samples, stable until three are held) and the change in memory
// use since the previous sample (zero on the first). a sample steps through
// intake with a read of the oldest window entry, the window update and
// running sum refresh with the memory write, the three slope products, and
// the threshold compare. the next sample is taken once the trend engine is
// back in idle, so a new sample is not taken before the last is through;
// a finished result sits in the output register while the next sample is
// worked on, and the compare step holds only if that register is still full.
// thresholds are written through the plain write port and must only change
// while no sample is in flight. no clearing pass is needed after reset.
module telemetry_trend_pressure_classifier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	ttpc_in_if.sink                             sample,
	ttpc_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [ttpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	ttpc_pkg::ttpc_cfg_t     cfg_q;
	ttpc_pkg::pressure_t     level;
	ttpc_pkg::pressure_t     pressure_q;
	ttpc_pkg::ttpc_eng_res_t eng_res;

	logic eng_busy;
	logic accept;
	logic out_free;

	logic                              out_valid_q;
	logic [ttpc_pkg::CODE_W-1:0]       out_pressure_q;
	logic [ttpc_pkg::CODE_W-1:0]       out_trend_q;
	logic signed [ttpc_pkg::CHG_W-1:0] out_change_q;

	// sample beat handshake: one sample in flight at a time
	assign sample.ready = !eng_busy;
	assign accept       = sample.valid && sample.ready;

	// output slot can take a result when empty or draining this cycle
	assign out_free = !out_valid_q || result.ready;

	// configuration registers, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ttpc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttpc_pkg::CFG_RAM_WARN:  cfg_q.mem_warn  <= cfg_wdata[ttpc_pkg::RAM_W-1:0];
				ttpc_pkg::CFG_RAM_CRIT:  cfg_q.mem_crit  <= cfg_wdata[ttpc_pkg::RAM_W-1:0];
				ttpc_pkg::CFG_TH_WARN:   cfg_q.th_warn   <= cfg_wdata[ttpc_pkg::TEMP_W-1:0];
				ttpc_pkg::CFG_TH_CRIT:   cfg_q.th_crit   <= cfg_wdata[ttpc_pkg::TEMP_W-1:0];
				ttpc_pkg::CFG_BAT_LOW:   cfg_q.bat_low   <= cfg_wdata[ttpc_pkg::BAT_W-1:0];
				ttpc_pkg::CFG_TREND_THR: cfg_q.trend_thr <= cfg_wdata[ttpc_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pressure is settled straight from the sample beat
	ttpc_pressure u_pressure (
		.mem_use         (sample.mem_use),
		.temperature     (sample.temperature),
		.battery_level   (sample.battery_level),
		.battery_present (sample.battery_present),
		.charging        (sample.charging),
		.cfg             (cfg_q),
		.level           (level)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pressure_q <= level;
		end
	end

	// window, change and slope
	ttpc_trend_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.mem_use   (sample.mem_use),
		.threshold (cfg_q.trend_thr),
		.out_free  (out_free),
		.busy      (eng_busy),
		.res       (eng_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res.done) begin
			out_pressure_q <= pressure_q;
			out_trend_q    <= eng_res.trend_code;
			out_change_q   <= eng_res.ram_change;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.pressure_level = out_pressure_q;
	assign result.trend_code     = out_trend_q;
	assign result.ram_change     = out_change_q;

endmodule

// ===== src/ttpc_pressure.sv =====
// pressure classifier: threshold compares and low battery rule
module ttpc_pressure (
	input  logic [ttpc_pkg::RAM_W-1:0]         mem_use,
	input  logic signed [ttpc_pkg::TEMP_W-1:0] temperature,
	input  logic [ttpc_pkg::BAT_W-1:0]         battery_level,
	input  logic                               battery_present,
	input  logic                               charging,
	input  ttpc_pkg::ttpc_cfg_t                cfg,
	output ttpc_pkg::pressure_t                level
);

	logic bat_low;
	logic mem_crit;
	logic mem_warn;
	logic th_crit;
	logic th_warn;

	always_comb begin
		bat_low  = battery_present && !charging && (battery_level < cfg.bat_low);
		mem_crit = mem_use >= cfg.mem_crit;
		mem_warn = mem_use >= cfg.mem_warn;
		th_crit  = $signed(temperature) >= $signed(cfg.th_crit);
		th_warn  = $signed(temperature) >= $signed(cfg.th_warn);
		if (mem_crit || th_crit || bat_low) begin
			level = ttpc_pkg::PRESSURE_CRITICAL;
		end else if (mem_warn || th_warn) begin
			level = ttpc_pkg::PRESSURE_WARN;
		end else begin
			level = ttpc_pkg::PRESSURE_NOMINAL;
		end
	end

endmodule

// ===== src/ttpc_trend_engine.sv =====
// trend engine: sample window memory, running sums and slope test
module ttpc_trend_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ttpc_pkg::RAM_W-1:0]       mem_use,
	input  logic [ttpc_pkg::THR_W-1:0]       threshold,
	input  logic                             out_free,
	output logic                             busy,
	output ttpc_pkg::ttpc_eng_res_t          res
);

	// window memory, circular, no reset
	logic [ttpc_pkg::RAM_W-1:0] mem [ttpc_pkg::WINDOW_DEPTH];
	logic [ttpc_pkg::RAM_W-1:0] rdata_q;

	ttpc_pkg::eng_state_t state_q, state_d;

	logic [ttpc_pkg::CNT_W-1:0] fill_q;
	logic [ttpc_pkg::PTR_W-1:0] wr_ptr_q;
	logic [ttpc_pkg::SY_W-1:0]  sy_q;
	logic [ttpc_pkg::SXY_W-1:0] sxy_q;
	logic [ttpc_pkg::RAM_W-1:0] prev_q;

	logic [ttpc_pkg::RAM_W-1:0]        ram_s1;
	logic signed [ttpc_pkg::CHG_W-1:0] change_s2;
	logic [ttpc_pkg::PA_W-1:0]         prod_a_s3;
	logic [ttpc_pkg::PB_W-1:0]         prod_b_s3;
	logic [ttpc_pkg::LIM_W-1:0]        lim_s3;

	logic                                  full;
	logic [ttpc_pkg::CNT_W-1:0]            idx;
	logic [ttpc_pkg::CNT_W+ttpc_pkg::RAM_W-1:0] idx_prod;
	logic [ttpc_pkg::SXY_W-1:0]            sxy_upd;
	logic [ttpc_pkg::SY_W-1:0]             sy_upd;
	logic [ttpc_pkg::PTR_W-1:0]            ptr_next;
	logic signed [ttpc_pkg::CMP_W-1:0]     num;
	logic signed [ttpc_pkg::CMP_W-1:0]     lim;
	ttpc_pkg::trend_t                      trend;

	// memory: read oldest at start, write new sample in update
	always_ff @(posedge clk) begin
		if (start) begin
			rdata_q <= mem[wr_ptr_q];
		end
		if (state_q == ttpc_pkg::ST_UPDATE) begin
			mem[wr_ptr_q] <= ram_s1;
		end
	end

	// window update arithmetic
	always_comb begin
		full     = fill_q == ttpc_pkg::CNT_W'(ttpc_pkg::WINDOW_DEPTH);
		idx      = full ? ttpc_pkg::CNT_W'(ttpc_pkg::WINDOW_DEPTH - 1) : fill_q;
		idx_prod = idx * ram_s1;
		// dropping the oldest shifts every x down by one
		sxy_upd  = sxy_q + ttpc_pkg::SXY_W'(idx_prod)
			+ (full ? (ttpc_pkg::SXY_W'(rdata_q) - ttpc_pkg::SXY_W'(sy_q)) : '0);
		sy_upd   = sy_q + ttpc_pkg::SY_W'(ram_s1)
			- (full ? ttpc_pkg::SY_W'(rdata_q) : '0);
		ptr_next = (wr_ptr_q == ttpc_pkg::PTR_W'(ttpc_pkg::WINDOW_DEPTH - 1))
			? '0 : wr_ptr_q + 1'b1;
	end

	// slope decision
	always_comb begin
		num = $signed(ttpc_pkg::CMP_W'(prod_a_s3)) - $signed(ttpc_pkg::CMP_W'(prod_b_s3));
		lim = $signed(ttpc_pkg::CMP_W'(lim_s3));
		if (fill_q < ttpc_pkg::CNT_W'(ttpc_pkg::MIN_FIT)) begin
			trend = ttpc_pkg::TREND_STABLE;
		end else if (num > lim) begin
			trend = ttpc_pkg::TREND_RISING;
		end else if (num < -lim) begin
			trend = ttpc_pkg::TREND_FALLING;
		end else begin
			trend = ttpc_pkg::TREND_STABLE;
		end
	end

	// sequencer
	always_comb begin
		state_d        = state_q;
		res.done       = 1'b0;
		res.trend_code = trend;
		res.ram_change = change_s2;
		busy           = state_q != ttpc_pkg::ST_IDLE;
		unique case (state_q)
			ttpc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ttpc_pkg::ST_UPDATE;
				end
			end
			ttpc_pkg::ST_UPDATE: begin
				state_d = ttpc_pkg::ST_MULT;
			end
			ttpc_pkg::ST_MULT: begin
				state_d = ttpc_pkg::ST_DECIDE;
			end
			ttpc_pkg::ST_DECIDE: begin
				if (out_free) begin
					res.done = 1'b1;
					state_d  = ttpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ttpc_pkg::ST_IDLE;
			fill_q   <= '0;
			wr_ptr_q <= '0;
			sy_q     <= '0;
			sxy_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ttpc_pkg::ST_UPDATE) begin
				sy_q     <= sy_upd;
				sxy_q    <= sxy_upd;
				wr_ptr_q <= ptr_next;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (start) begin
			ram_s1 <= mem_use;
		end
		if (state_q == ttpc_pkg::ST_UPDATE) begin
			prev_q    <= ram_s1;
			change_s2 <= (fill_q == '0) ? '0
				: $signed({1'b0, ram_s1}) - $signed({1'b0, prev_q});
		end
		if (state_q == ttpc_pkg::ST_MULT) begin
			prod_a_s3 <= fill_q * sxy_q;
			prod_b_s3 <= ttpc_pkg::SX_TABLE[fill_q] * sy_q;
			lim_s3    <= threshold * ttpc_pkg::DEN_TABLE[fill_q];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ttpc_pkg::CNT_W'(ttpc_pkg::WINDOW_DEPTH))
		else $error("window fill beyond depth");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ttpc_pkg::ST_IDLE)
		else $error("sample started while engine busy");

	a_start_update: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ttpc_pkg::ST_UPDATE)
		else $error("start did not lead to window update");

	a_decide_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttpc_pkg::ST_DECIDE && !out_free) |=> state_q == ttpc_pkg::ST_DECIDE)
		else $error("result dropped while output slot occupied");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= ttpc_pkg::PTR_W'(ttpc_pkg::WINDOW_DEPTH - 1))
		else $error("window pointer out of range");

endmodule
